// File: sv/mac_pkg.sv
// Shared types and constants for the moving average crossover block
`timescale 1ns / 1ps

package mac_pkg;

   // configuration register indexes and field widths
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int LEN_CFG_W   = 9;
   localparam int BAND_W      = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_FAST_LEN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLOW_LEN = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAND     = 2'd2;

   localparam logic [LEN_CFG_W-1:0] FAST_LEN_RESET = 9'd5;
   localparam logic [LEN_CFG_W-1:0] SLOW_LEN_RESET = 9'd20;
   localparam logic [BAND_W-1:0]    BAND_RESET     = 16'd0;

   // band is a Q0.16 fraction, so unity is one shifted by this much
   localparam int BAND_FRAC_BITS = 16;

   // position, encoded as the two bit signed result
   typedef enum logic [1:0] {
      POS_FLAT  = 2'b00,
      POS_LONG  = 2'b01,
      POS_SHORT = 2'b11
   } pos_type;

   // control that travels with each window job
   typedef struct packed {
      logic restart;
      logic full;
   } job_ctl_type;

   typedef enum logic [1:0] {
      WIN_IDLE,
      WIN_SWEEP,
      WIN_SEND
   } win_state_type;

   typedef enum logic [1:0] {
      DEC_IDLE,
      DEC_BAND,
      DEC_CMP,
      DEC_OUT
   } dec_state_type;

endpackage

// File: sv/mac_queue.sv
// Small first-in first-out queue with push/full and pop/empty sides
`timescale 1ns / 1ps

module mac_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   import mac_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/mac_window.sv
// Price ring and window sum sequencer: stores each price and, once the slow window is full, sums both windows
`timescale 1ns / 1ps

module mac_window #(
   parameter int WINDOW_DEPTH = 256,
   parameter int PRICE_BITS   = 24
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_empty,
   output logic                                        in_pop,
   input  logic [PRICE_BITS-1:0]                       in_price,
   input  logic                                        in_new_series,
   input  logic [mac_pkg::LEN_CFG_W-1:0]               cfg_fast_len,
   input  logic [mac_pkg::LEN_CFG_W-1:0]               cfg_slow_len,
   output logic                                        job_valid,
   input  logic                                        job_ready,
   output mac_pkg::job_ctl_type                        job_ctl,
   output logic [PRICE_BITS+$clog2(WINDOW_DEPTH)-1:0]  job_fast_sum,
   output logic [PRICE_BITS+$clog2(WINDOW_DEPTH)-1:0]  job_slow_sum,
   output logic [$clog2(WINDOW_DEPTH+1)-1:0]           job_fast_len,
   output logic [$clog2(WINDOW_DEPTH+1)-1:0]           job_slow_len
);
   import mac_pkg::*;

   localparam int AW    = $clog2(WINDOW_DEPTH);
   localparam int LEN_W = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W = PRICE_BITS + AW;
   localparam logic [AW-1:0]    LAST_ADDR = AW'(WINDOW_DEPTH - 1);
   localparam logic [LEN_W-1:0] LEN_DEPTH = LEN_W'(WINDOW_DEPTH);
   localparam logic [LEN_W-1:0] LEN_ONE   = LEN_W'(1);

   logic [PRICE_BITS-1:0] ring_mem [WINDOW_DEPTH];
   logic [PRICE_BITS-1:0] rdata_ff;

   win_state_type state_ff, state_in;
   logic [AW-1:0]     wi_ff, wi_in;
   logic [LEN_W-1:0]  fill_ff, fill_in;
   logic [LEN_W-1:0]  sl_ff, sl_in, fl_ff, fl_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [LEN_W-1:0]  issue_ff, issue_in;
   logic              pend_ff, pend_in, pend_fast_ff, pend_fast_in;
   logic [SUM_W-1:0]  fsum_ff, fsum_in, ssum_ff, ssum_in;
   job_ctl_type       ctl_ff, ctl_in;

   logic [31:0]       slow_req, fast_req;
   logic [LEN_W-1:0]  sl_eff, fl_eff;
   logic [AW-1:0]     wi_base;
   logic [LEN_W-1:0]  fill_base, fill_new;
   logic              mem_we, mem_re, issue_go;

   // clamp the window lengths to the ring and to each other
   always_comb begin
      slow_req = 32'(cfg_slow_len);
      fast_req = 32'(cfg_fast_len);
      if (slow_req == 32'd0) begin
         sl_eff = LEN_ONE;
      end else if (slow_req > 32'(WINDOW_DEPTH)) begin
         sl_eff = LEN_DEPTH;
      end else begin
         sl_eff = LEN_W'(slow_req);
      end
      if (fast_req == 32'd0) begin
         fl_eff = LEN_ONE;
      end else if (fast_req > 32'(sl_eff)) begin
         fl_eff = sl_eff;
      end else begin
         fl_eff = LEN_W'(fast_req);
      end
   end

   // ring position of this price, after an optional restart
   assign wi_base   = in_new_series ? '0 : wi_ff;
   assign fill_base = in_new_series ? '0 : fill_ff;
   assign fill_new  = (fill_base == LEN_DEPTH) ? fill_base : fill_base + 1'b1;
   assign issue_go  = (issue_ff != sl_ff);

   // sequencer: take a price, sweep the ring newest first once the slow window is full, hand over the sums
   always_comb begin
      state_in     = state_ff;
      wi_in        = wi_ff;
      fill_in      = fill_ff;
      sl_in        = sl_ff;
      fl_in        = fl_ff;
      addr_in      = addr_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      pend_fast_in = 1'b0;
      fsum_in      = fsum_ff;
      ssum_in      = ssum_ff;
      ctl_in       = ctl_ff;
      in_pop       = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      job_valid    = 1'b0;
      unique case (state_ff)
         WIN_IDLE: begin
            if (!in_empty) begin
               in_pop         = 1'b1;
               mem_we         = 1'b1;
               wi_in          = (wi_base == LAST_ADDR) ? '0 : wi_base + 1'b1;
               fill_in        = fill_new;
               sl_in          = sl_eff;
               fl_in          = fl_eff;
               addr_in        = wi_base;
               issue_in       = '0;
               fsum_in        = '0;
               ssum_in        = '0;
               ctl_in.restart = in_new_series;
               ctl_in.full    = (fill_new >= sl_eff);
               state_in       = (fill_new >= sl_eff) ? WIN_SWEEP : WIN_SEND;
            end
         end
         WIN_SWEEP: begin
            if (issue_go) begin
               mem_re       = 1'b1;
               pend_in      = 1'b1;
               pend_fast_in = (issue_ff < fl_ff);
               issue_in     = issue_ff + 1'b1;
               addr_in      = (addr_ff == '0) ? LAST_ADDR : addr_ff - 1'b1;
            end else begin
               state_in = WIN_SEND;
            end
            if (pend_ff) begin
               ssum_in = ssum_ff + SUM_W'(rdata_ff);
               if (pend_fast_ff) begin
                  fsum_in = fsum_ff + SUM_W'(rdata_ff);
               end
            end
         end
         WIN_SEND: begin
            job_valid = 1'b1;
            if (job_ready) begin
               state_in = WIN_IDLE;
            end
         end
         default: state_in = WIN_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= WIN_IDLE;
         wi_ff        <= '0;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         pend_fast_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wi_ff        <= wi_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         pend_fast_ff <= pend_fast_in;
      end
   end

   // per-item working registers
   always_ff @(posedge clock) begin
      sl_ff    <= sl_in;
      fl_ff    <= fl_in;
      addr_ff  <= addr_in;
      issue_ff <= issue_in;
      fsum_ff  <= fsum_in;
      ssum_ff  <= ssum_in;
      ctl_ff   <= ctl_in;
   end

   // price ring, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[wi_base] <= in_price;
      end
      if (mem_re) begin
         rdata_ff <= ring_mem[addr_ff];
      end
   end

   assign job_ctl      = ctl_ff;
   assign job_fast_sum = fsum_ff;
   assign job_slow_sum = ssum_ff;
   assign job_fast_len = fl_ff;
   assign job_slow_len = sl_ff;

`ifndef SYNTHESIS
   // a full job has summed exactly the slow window
   a_sweep_length: assert property (@(posedge clock) disable iff (reset)
      job_valid && ctl_ff.full |-> issue_ff == sl_ff)
      else $error("window sweep did not cover the slow window");

   // a full job only when the ring holds enough prices
   a_full_fill: assert property (@(posedge clock) disable iff (reset)
      job_valid && ctl_ff.full |-> fill_ff >= sl_ff && fl_ff <= sl_ff)
      else $error("full job with too few prices in the ring");
`endif

endmodule

// File: sv/mac_decide.sv
// Cross-multiplied average compare against the band and position tracking
`timescale 1ns / 1ps

module mac_decide #(
   parameter int WINDOW_DEPTH = 256,
   parameter int PRICE_BITS   = 24
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        job_valid,
   output logic                                        job_ready,
   input  mac_pkg::job_ctl_type                        job_ctl,
   input  logic [PRICE_BITS+$clog2(WINDOW_DEPTH)-1:0]  job_fast_sum,
   input  logic [PRICE_BITS+$clog2(WINDOW_DEPTH)-1:0]  job_slow_sum,
   input  logic [$clog2(WINDOW_DEPTH+1)-1:0]           job_fast_len,
   input  logic [$clog2(WINDOW_DEPTH+1)-1:0]           job_slow_len,
   input  logic [mac_pkg::BAND_W-1:0]                  band,
   input  logic                                        res_full,
   output logic                                        res_push,
   output logic [1:0]                                  res_signal,
   output logic                                        res_window_full
);
   import mac_pkg::*;

   localparam int LEN_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W  = PRICE_BITS + $clog2(WINDOW_DEPTH);
   localparam int PROD_W = SUM_W + LEN_W;
   localparam int C_W    = PROD_W + BAND_W;
   localparam int CMP_W  = PROD_W + BAND_FRAC_BITS + 2;

   dec_state_type state_ff, state_in;
   pos_type       pos_ff, pos_in;
   logic          wfull_ff, wfull_in;
   logic [PROD_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [C_W-1:0]    c_ff, c_in;
   logic [PROD_W:0]   diff_ff, diff_in;

   logic [CMP_W-1:0]  shifted, c_ext, up_gap, dn_gap;
   logic              above_up, below_dn, gt_mid, lt_mid;

   // fast*slow_len*2^16 against slow*fast_len*(2^16 +/- band), via the difference
   assign shifted  = {diff_ff[PROD_W], diff_ff, {BAND_FRAC_BITS{1'b0}}};
   assign c_ext    = {2'b00, c_ff};
   assign up_gap   = shifted - c_ext;
   assign dn_gap   = shifted + c_ext;
   assign above_up = !up_gap[CMP_W-1] && (up_gap != '0);
   assign below_dn = dn_gap[CMP_W-1];
   assign gt_mid   = !diff_ff[PROD_W] && (diff_ff != '0);
   assign lt_mid   = diff_ff[PROD_W];

   // stage sequencer and position update
   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      wfull_in  = wfull_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      diff_in   = diff_ff;
      job_ready = 1'b0;
      res_push  = 1'b0;
      unique case (state_ff)
         DEC_IDLE: begin
            job_ready = 1'b1;
            if (job_valid) begin
               wfull_in = job_ctl.full;
               a_in     = job_fast_sum * job_slow_len;
               b_in     = job_slow_sum * job_fast_len;
               if (!job_ctl.full || job_ctl.restart) begin
                  pos_in = POS_FLAT;
               end
               state_in = job_ctl.full ? DEC_BAND : DEC_OUT;
            end
         end
         DEC_BAND: begin
            c_in     = b_ff * band;
            diff_in  = {1'b0, a_ff} - {1'b0, b_ff};
            state_in = DEC_CMP;
         end
         DEC_CMP: begin
            unique case (pos_ff)
               POS_LONG: begin
                  if (lt_mid) begin
                     pos_in = below_dn ? POS_SHORT : POS_FLAT;
                  end
               end
               POS_SHORT: begin
                  if (gt_mid) begin
                     pos_in = above_up ? POS_LONG : POS_FLAT;
                  end
               end
               POS_FLAT: begin
                  pos_in = above_up ? POS_LONG : (below_dn ? POS_SHORT : POS_FLAT);
               end
               default: pos_in = POS_FLAT;
            endcase
            state_in = DEC_OUT;
         end
         DEC_OUT: begin
            if (!res_full) begin
               res_push = 1'b1;
               state_in = DEC_IDLE;
            end
         end
         default: state_in = DEC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DEC_IDLE;
         pos_ff   <= POS_FLAT;
         wfull_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         wfull_ff <= wfull_in;
      end
   end

   // product pipeline registers
   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      diff_ff <= diff_in;
   end

   assign res_signal      = pos_ff;
   assign res_window_full = wfull_ff;

`ifndef SYNTHESIS
   // a word before the slow window fills always reports flat
   a_flat_until_full: assert property (@(posedge clock) disable iff (reset)
      res_push && !res_window_full |-> res_signal == POS_FLAT)
      else $error("non-flat position reported before the window is full");

   // position moves only when a job is taken or at the compare stage
   a_pos_update_point: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (pos_ff != $past(pos_ff)) |->
         ($past(state_ff) == DEC_IDLE) || ($past(state_ff) == DEC_CMP))
      else $error("position changed outside its update stages");
`endif

endmodule

// File: sv/ma_crossover_signal.sv
// Moving average crossover signal top level: queues, window engine and decision stage
//
// Each price word pushed in yields one result word holding the position after
// that price (-1 short, 0 flat, 1 long) and a window-full flag. The ring
// stores every price, and once the slow window is full both window sums are
// rebuilt for each price from the newest slow_len prices, one ring read per
// cycle through a single read port. The compare stage overlaps the next sweep.
// A two-word input queue and a two-word result queue let either side stall
// without blocking the other. There is no clearing pass after reset;
// configuration writes should be made while the block is idle and take
// effect on the next price.
`timescale 1ns / 1ps

module ma_crossover_signal #(
   parameter int WINDOW_DEPTH = 256,
   parameter int PRICE_BITS   = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [PRICE_BITS-1:0]              req_price,
   input  logic                               req_new_series,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic signed [1:0]                  rsp_signal,
   output logic                               rsp_window_full,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mac_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mac_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import mac_pkg::*;

   localparam int LEN_W   = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W   = PRICE_BITS + $clog2(WINDOW_DEPTH);
   localparam int IN_W    = PRICE_BITS + 1;
   localparam int OUT_W   = 3;
   localparam int QUEUE_D = 2;

   logic [LEN_CFG_W-1:0] fast_len_ff, fast_len_in;
   logic [LEN_CFG_W-1:0] slow_len_ff, slow_len_in;
   logic [BAND_W-1:0]    band_ff, band_in;

   logic [IN_W-1:0]   in_word;
   logic              in_empty, in_pop;
   logic              job_valid, job_ready;
   job_ctl_type       job_ctl;
   logic [SUM_W-1:0]  job_fast_sum, job_slow_sum;
   logic [LEN_W-1:0]  job_fast_len, job_slow_len;
   logic              res_push, res_full, res_window_full;
   logic [1:0]        res_signal;
   logic [OUT_W-1:0]  out_word;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      fast_len_in = fast_len_ff;
      slow_len_in = slow_len_ff;
      band_in     = band_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FAST_LEN: fast_len_in = csr_wdata[LEN_CFG_W-1:0];
            CSR_SLOW_LEN: slow_len_in = csr_wdata[LEN_CFG_W-1:0];
            CSR_BAND:     band_in     = csr_wdata[BAND_W-1:0];
            default:      band_in     = band_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_len_ff <= FAST_LEN_RESET;
         slow_len_ff <= SLOW_LEN_RESET;
         band_ff     <= BAND_RESET;
      end else begin
         fast_len_ff <= fast_len_in;
         slow_len_ff <= slow_len_in;
         band_ff     <= band_in;
      end
   end

   // front: input word queue
   mac_queue #(
      .WIDTH (IN_W),
      .DEPTH (QUEUE_D)
   ) u_in_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data ({req_new_series, req_price}),
      .full      (req_full),
      .pop       (in_pop),
      .pop_data  (in_word),
      .empty     (in_empty)
   );

   // back: ring and window sums
   mac_window #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .PRICE_BITS   (PRICE_BITS)
   ) u_window (
      .clock         (clock),
      .reset         (reset),
      .in_empty      (in_empty),
      .in_pop        (in_pop),
      .in_price      (in_word[PRICE_BITS-1:0]),
      .in_new_series (in_word[IN_W-1]),
      .cfg_fast_len  (fast_len_ff),
      .cfg_slow_len  (slow_len_ff),
      .job_valid     (job_valid),
      .job_ready     (job_ready),
      .job_ctl       (job_ctl),
      .job_fast_sum  (job_fast_sum),
      .job_slow_sum  (job_slow_sum),
      .job_fast_len  (job_fast_len),
      .job_slow_len  (job_slow_len)
   );

   // back: compare and position
   mac_decide #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .PRICE_BITS   (PRICE_BITS)
   ) u_decide (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (job_valid),
      .job_ready       (job_ready),
      .job_ctl         (job_ctl),
      .job_fast_sum    (job_fast_sum),
      .job_slow_sum    (job_slow_sum),
      .job_fast_len    (job_fast_len),
      .job_slow_len    (job_slow_len),
      .band            (band_ff),
      .res_full        (res_full),
      .res_push        (res_push),
      .res_signal      (res_signal),
      .res_window_full (res_window_full)
   );

   // result word queue
   mac_queue #(
      .WIDTH (OUT_W),
      .DEPTH (QUEUE_D)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data ({res_signal, res_window_full}),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (out_word),
      .empty     (rsp_empty)
   );

   assign rsp_signal      = $signed(out_word[2:1]);
   assign rsp_window_full = out_word[0];

endmodule

// File: tb/sv/tb_ma_crossover_signal.sv
// Self-checking testbench for the moving average crossover signal block
`timescale 1ns / 1ps

module tb_ma_crossover_signal;
   import mac_pkg::*;

   localparam int RING_DEPTH  = 256;
   localparam int PRICE_W     = 24;
   localparam int ITEM_TARGET = 1300;
   localparam int TAIL_CYCLES = 300;
   localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};
   // index with no register behind it; a write there changes nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   // what one result word should carry
   typedef struct packed {
      pos_type pos;
      logic    full;
   } crossover_word_type;

   // block ports
   logic                    clock          = 1'b0;
   logic                    reset          = 1'b1;
   logic                    req_push       = 1'b0;
   logic                    req_full;
   logic [PRICE_W-1:0]      req_price      = '0;
   logic                    req_new_series = 1'b0;
   logic                    rsp_empty;
   logic                    rsp_pop        = 1'b0;
   logic signed [1:0]       rsp_signal;
   logic                    rsp_window_full;
   logic                    csr_valid      = 1'b0;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index      = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata      = '0;

   // crossover predictor state
   logic [PRICE_W-1:0]      price_ring [RING_DEPTH];
   logic [7:0]              ring_head;
   logic [8:0]              ring_count;
   pos_type                 held_pos;
   logic [8:0]              fast_cfg;
   logic [8:0]              slow_cfg;
   logic [15:0]             band_cfg;
   crossover_word_type      pending_words [$];
   crossover_word_type      front_word;

   // bookkeeping
   int mismatch_count = 0;
   int items_sent     = 0;
   int words_checked  = 0;
   int long_words     = 0;
   int short_words    = 0;
   int phase_count    = 0;

   // sender burst and receiver stall state
   int burst_left = 0;
   bit gappy      = 1'b1;
   int stall_mode = 0;
   int mode_left  = 0;
   int stall_left = 0;

   ma_crossover_signal #(
      .WINDOW_DEPTH(RING_DEPTH),
      .PRICE_BITS  (PRICE_W)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_price      (req_price),
      .req_new_series (req_new_series),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_signal     (rsp_signal),
      .rsp_window_full(rsp_window_full),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // clock
   initial begin
      forever #2 clock = ~clock;
   end

   // store one price and work out the position word it produces
   function automatic crossover_word_type predict_crossover(input logic [PRICE_W-1:0] price,
                                                            input logic restart);
      logic [63:0]        sl;
      logic [63:0]        fl;
      logic [63:0]        fast_total;
      logic [63:0]        slow_total;
      logic [63:0]        lhs;
      logic [63:0]        mid;
      logic [63:0]        up;
      logic [63:0]        dn;
      logic [7:0]         idx;
      logic               above_up;
      logic               below_dn;
      crossover_word_type w;
      sl = 64'(slow_cfg);
      if (sl == 64'd0) sl = 64'd1;
      if (sl > 64'(RING_DEPTH)) sl = 64'(RING_DEPTH);
      fl = 64'(fast_cfg);
      if (fl == 64'd0) fl = 64'd1;
      if (fl > sl) fl = sl;
      if (restart) begin
         ring_count = '0;
         ring_head  = '0;
         held_pos   = POS_FLAT;
      end
      price_ring[ring_head] = price;
      ring_head = ring_head + 8'd1;
      if (ring_count < RING_DEPTH) ring_count = ring_count + 9'd1;
      if (ring_count < sl) begin
         held_pos = POS_FLAT;
      end else begin
         // both window sums from the newest prices back
         fast_total = '0;
         slow_total = '0;
         for (int k = 0; k < sl; k++) begin
            idx = ring_head - 8'd1 - 8'(k);
            slow_total += price_ring[idx];
            if (k < fl) fast_total += price_ring[idx];
         end
         // cross-multiplied compares, no division
         lhs = fast_total * sl * 64'd65536;
         mid = slow_total * fl * 64'd65536;
         up  = slow_total * fl * (64'd65536 + band_cfg);
         dn  = slow_total * fl * (64'd65536 - band_cfg);
         above_up = lhs > up;
         below_dn = lhs < dn;
         case (held_pos)
            POS_LONG: begin
               if (lhs < mid) held_pos = below_dn ? POS_SHORT : POS_FLAT;
            end
            POS_SHORT: begin
               if (lhs > mid) held_pos = above_up ? POS_LONG : POS_FLAT;
            end
            default: begin
               held_pos = above_up ? POS_LONG : (below_dn ? POS_SHORT : POS_FLAT);
            end
         endcase
      end
      w.pos  = held_pos;
      w.full = ring_count >= sl;
      return w;
   endfunction

   // one register write over the csr channel
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      if (!csr_valid) csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FAST_LEN: fast_cfg = data[8:0];
         CSR_SLOW_LEN: slow_cfg = data[8:0];
         CSR_BAND:     band_cfg = data;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [15:0] fast_w, input logic [15:0] slow_w,
                            input logic [15:0] band_w);
      write_csr(CSR_FAST_LEN, fast_w);
      write_csr(CSR_SLOW_LEN, slow_w);
      write_csr(CSR_BAND, band_w);
      csr_valid <= 1'b0;
   endtask

   // push one price word and record its expected result
   task automatic send_price(input logic [PRICE_W-1:0] price, input logic restart);
      if (!req_push) req_push <= 1'b1;
      req_price      <= price;
      req_new_series <= restart;
      do @(posedge clock); while (req_full);
      pending_words.push_back(predict_crossover(price, restart));
      items_sent++;
      // bursts, with random gaps between them when gappy is set
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         if (gappy) begin
            req_push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
   endtask

   // hold off until every expected word has come back
   task automatic wait_drained();
      if (req_push) req_push <= 1'b0;
      do @(posedge clock); while (pending_words.size() != 0);
   endtask

   // window fill, long and short reversals at zero band, new series
   task automatic test_short_windows();
      configure(16'hFE00, 16'd3, 16'd0);
      send_price(24'd0, 1'b1);
      send_price(24'd0, 1'b0);
      send_price(PRICE_MAX, 1'b0);
      send_price(24'd0, 1'b0);
      send_price(PRICE_MAX, 1'b0);
      send_price(24'd5, 1'b1);
      wait_drained();
   endtask

   // zero slow length, fast longer than slow, widest band, unused index
   task automatic test_clamped_lengths();
      write_csr(CSR_FAST_LEN, 16'd300);
      write_csr(CSR_SLOW_LEN, 16'd0);
      write_csr(CSR_BAND, 16'hFFFF);
      write_csr(CSR_SPARE, 16'hFFFF);
      csr_valid <= 1'b0;
      send_price(PRICE_MAX, 1'b1);
      send_price(24'd0, 1'b0);
      wait_drained();
   endtask

   // quarter band: long, fall back to flat inside band, short, back to flat
   task automatic test_band_hysteresis();
      configure(16'd1, 16'd2, 16'h4000);
      send_price(24'd100, 1'b1);
      send_price(24'd100, 1'b0);
      send_price(24'd200, 1'b0);
      send_price(24'd140, 1'b0);
      send_price(24'd100, 1'b0);
      send_price(24'd50, 1'b0);
      send_price(24'd80, 1'b0);
      wait_drained();
   endtask

   // slow window grows past the fill count mid series, also past the ring
   task automatic test_length_change();
      configure(16'd1, 16'd2, 16'd0);
      send_price(24'd10, 1'b1);
      send_price(24'd20, 1'b0);
      send_price(24'd30, 1'b0);
      wait_drained();
      configure(16'd1, 16'h01FF, 16'd0);
      send_price(24'd40, 1'b0);
      wait_drained();
      configure(16'd2, 16'd5, 16'd0);
      send_price(24'd50, 1'b0);
      send_price(24'd60, 1'b0);
      wait_drained();
   endtask

   // trending price walks under random settings, a few with the full ring
   task automatic test_random_phases();
      logic [8:0]          slow9;
      logic [8:0]          fast9;
      logic [15:0]         band_w;
      logic [PRICE_W-1:0]  p;
      logic                restart;
      int                  slow_eff;
      int                  count;
      int                  big_phases;
      int                  spread;
      int                  drift;
      int                  seg_left;
      int                  walk;
      big_phases = 0;
      walk       = $urandom_range(0, PRICE_MAX);
      while (items_sent < ITEM_TARGET) begin
         wait_drained();
         phase_count++;
         case ($urandom_range(0, 15))
            0: begin
               if (big_phases < 3) begin
                  slow9 = 9'($urandom_range(256, 511));
                  big_phases++;
               end else begin
                  slow9 = 9'($urandom_range(1, 32));
               end
            end
            1:       slow9 = 9'd0;
            default: slow9 = 9'($urandom_range(1, 32));
         endcase
         slow_eff = (slow9 == 0) ? 1 : ((slow9 > RING_DEPTH) ? RING_DEPTH : int'(slow9));
         fast9 = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                              : 9'($urandom_range(1, slow_eff));
         band_w = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4096));
         configure({7'($urandom), fast9}, {7'($urandom), slow9}, band_w);
         gappy    = $urandom_range(0, 3) != 0;
         spread   = 1 << $urandom_range(0, 16);
         seg_left = 0;
         count    = (slow_eff > 32) ? slow_eff + $urandom_range(20, 60) : $urandom_range(20, 60);
         for (int n = 0; n < count; n++) begin
            // new series at some starts of small phases, rarely inside them
            if (n == 0) restart = (slow_eff <= 32) && ($urandom_range(0, 1) == 0);
            else        restart = (slow_eff <= 32) && ($urandom_range(0, 49) == 0);
            if (restart) walk = $urandom_range(0, PRICE_MAX);
            if (seg_left == 0) begin
               seg_left = $urandom_range(3, 40);
               drift    = int'($urandom_range(0, 2 * spread)) - spread;
            end
            seg_left--;
            walk = walk + drift + int'($urandom_range(0, spread)) - spread / 2;
            if (walk < 0) walk = 0;
            if (walk > int'(PRICE_MAX)) walk = int'(PRICE_MAX);
            // occasional wild price
            if ($urandom_range(0, 19) == 0) p = PRICE_W'($urandom);
            else                            p = PRICE_W'(walk);
            send_price(p, restart);
         end
      end
   endtask

   // result side: check each popped word, then pick the next pop
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_words.size() == 0) begin
            $display("%0t: word with nothing expected: signal %0d full %0b",
                     $time, rsp_signal, rsp_window_full);
            mismatch_count++;
         end else begin
            front_word = pending_words.pop_front();
            words_checked++;
            if (front_word.pos == POS_LONG)  long_words++;
            if (front_word.pos == POS_SHORT) short_words++;
            if (rsp_signal !== front_word.pos) begin
               $display("%0t: signal expected %s actual %0d",
                        $time, front_word.pos.name(), rsp_signal);
               mismatch_count++;
            end
            if (rsp_window_full !== front_word.full) begin
               $display("%0t: window_full expected %0b actual %0b",
                        $time, front_word.full, rsp_window_full);
               mismatch_count++;
            end
         end
      end
      // stall pattern changes every so often
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         0:       rsp_pop <= 1'b1;
         1:       rsp_pop <= ($urandom_range(0, 1) == 1);
         2:       rsp_pop <= (mode_left % 4 == 0);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_pop <= 1'b0;
            end else begin
               stall_left = $urandom_range(0, 30);
               rsp_pop <= 1'b1;
            end
         end
      endcase
   end

   // test sequence
   initial begin
      fast_cfg   = FAST_LEN_RESET;
      slow_cfg   = SLOW_LEN_RESET;
      band_cfg   = BAND_RESET;
      ring_head  = '0;
      ring_count = '0;
      held_pos   = POS_FLAT;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_short_windows();
      test_clamped_lengths();
      test_band_hysteresis();
      test_length_change();
      test_random_phases();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("run covered %0d prices over %0d random settings, %0d words checked",
               items_sent, phase_count, words_checked);
      $display("positions seen: %0d long words, %0d short words", long_words, short_words);
      if (mismatch_count == 0 && pending_words.size() == 0) begin
         $display("tb_ma_crossover_signal: clean");
      end else begin
         $display("tb_ma_crossover_signal: errors");
      end
      $finish;
   end

   // watchdog
   initial begin
      #8_000_000;
      $display("tb_ma_crossover_signal: errors");
      $finish;
   end

endmodule

// File: filelist.f
sv/mac_pkg.sv
sv/mac_queue.sv
sv/mac_window.sv
sv/mac_decide.sv
sv/ma_crossover_signal.sv
tb/sv/tb_ma_crossover_signal.sv
